// ===== design/est_pkg.sv =====
// shared types and constants for the engine speed and throttle block
// no dependencies; imported by the controller, datapath and top level
`default_nettype none

package est_pkg;

    localparam int unsigned GAIN_W = 20;
    localparam int unsigned FLD_W  = 17;

    // sequencer steps, one product of the shared multiplier per step
    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_OFF_MUL,
        S_OFF_UPD,
        S_SM_M1,
        S_SM_M2,
        S_SM_R,
        S_SM_M3,
        S_SM_M4,
        S_SM_ST,
        S_CT_LOW,
        S_CT_M1,
        S_CT_M2,
        S_CT_M3,
        S_CT_M4,
        S_CT_M5,
        S_CT_M6,
        S_CT_M7,
        S_CT_M8,
        S_CT_M9,
        S_AM_M1,
        S_AM_M2,
        S_AM_M3,
        S_AM_M4,
        S_AM_M5,
        S_OU_M1,
        S_OU_M2,
        S_OU_M3,
        S_OU_M4,
        S_OU_M5,
        S_DONE
    } st_t;

    typedef enum logic [0:0] {
        CFG_PROP_GAIN  = 1'b0,
        CFG_INTEG_GAIN = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        st_t  step;
        logic load;
        logic publish;
    } cmd_t;

    typedef struct packed {
        logic ign;
        logic tgt_nz;
        logic cur_low;
    } status_t;

endpackage

`default_nettype wire

// ===== design/est_ctrl.sv =====
// sequencer for the engine speed and throttle block
// depends on est_pkg; drives the datapath through cmd_t, reads status_t
`default_nettype none

module est_ctrl
    import est_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    s_tvalid,
    output logic         s_tready,
    output logic         m_tvalid,
    input  wire logic    m_tready,
    input  wire status_t stat,
    output cmd_t         cmd
);

    st_t  state_reg, state_next;
    logic out_valid_reg, out_valid_next;
    logic accept;
    logic can_pub;

    assign accept  = s_tvalid && (state_reg == S_IDLE);
    assign can_pub = !out_valid_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:     if (accept) state_next = S_DISPATCH;
            S_DISPATCH: state_next = stat.ign ? S_SM_M1 : S_OFF_MUL;
            S_OFF_MUL:  state_next = S_OFF_UPD;
            S_OFF_UPD:  state_next = S_OU_M1;
            S_SM_M1:    state_next = S_SM_M2;
            S_SM_M2:    state_next = S_SM_R;
            S_SM_R:     state_next = S_SM_M3;
            S_SM_M3:    state_next = S_SM_M4;
            S_SM_M4:    state_next = S_SM_ST;
            S_SM_ST:
            begin
                if (!stat.tgt_nz)
                    state_next = S_AM_M1;
                else if (stat.cur_low)
                    state_next = S_CT_LOW;
                else
                    state_next = S_CT_M1;
            end
            S_CT_LOW:   state_next = S_AM_M1;
            S_CT_M1:    state_next = S_CT_M2;
            S_CT_M2:    state_next = S_CT_M3;
            S_CT_M3:    state_next = S_CT_M4;
            S_CT_M4:    state_next = S_CT_M5;
            S_CT_M5:    state_next = S_CT_M6;
            S_CT_M6:    state_next = S_CT_M7;
            S_CT_M7:    state_next = S_CT_M8;
            S_CT_M8:    state_next = S_CT_M9;
            S_CT_M9:    state_next = S_AM_M1;
            S_AM_M1:    state_next = S_AM_M2;
            S_AM_M2:    state_next = S_AM_M3;
            S_AM_M3:    state_next = S_AM_M4;
            S_AM_M4:    state_next = S_AM_M5;
            S_AM_M5:    state_next = S_OU_M1;
            S_OU_M1:    state_next = S_OU_M2;
            S_OU_M2:    state_next = S_OU_M3;
            S_OU_M3:    state_next = S_OU_M4;
            S_OU_M4:    state_next = S_OU_M5;
            S_OU_M5:    state_next = S_DONE;
            S_DONE:     if (can_pub) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.step    = state_reg;
        cmd.load    = accept;
        cmd.publish = (state_reg == S_DONE) && can_pub;
        s_tready    = (state_reg == S_IDLE);
        m_tvalid    = out_valid_reg;
        if (cmd.publish)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_pub_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |-> (!out_valid_reg || m_tready))
        else $error("result written over a beat not yet taken");

    a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == S_DISPATCH))
        else $error("accepted beat not dispatched");

    a_done_shows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && can_pub) |=> (state_reg == S_IDLE && m_tvalid))
        else $error("finished update not presented");

endmodule

`default_nettype wire

// ===== design/est_dp.sv =====
// datapath for the engine speed and throttle block: state, shared multiplier
// depends on est_pkg; steered step by step by est_ctrl
`default_nettype none

module est_dp
    import est_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire cmd_t          cmd,
    output status_t            stat,
    input  wire logic          cfg_we,
    input  wire logic [0:0]    cfg_index,
    input  wire logic [19:0]   cfg_data,
    input  wire logic [16:0]   step_time,
    input  wire logic [16:0]   throttle_cmd,
    input  wire logic [16:0]   speed_target,
    input  wire logic          ignition_on,
    input  wire logic          starter_press,
    output logic [16:0]        engine_speed,
    output logic [16:0]        engine_load,
    output logic [12:0]        exhaust_flow,
    output logic [17:0]        manifold_pressure,
    output logic               starter_active
);

    localparam logic [16:0] ONE_V = 17'd65536;

    function automatic logic signed [43:0] shr_tz(input logic signed [43:0] v,
                                                   input logic [4:0] sh);
        logic [43:0] mag;
        logic [43:0] q;
        begin
            mag = v[43] ? 44'(-v) : 44'(v);
            q   = mag >> sh;
            return v[43] ? -$signed(q) : $signed(q);
        end
    endfunction

    // architectural state
    logic [16:0] cur_reg, cur_next;
    logic [16:0] ratio_reg, ratio_next;
    logic [16:0] st_reg, st_next;
    logic signed [17:0] integ_reg, integ_next;
    logic [16:0] prev_spd_reg, prev_spd_next;
    logic signed [18:0] prev_drv_reg, prev_drv_next;
    logic latch_reg, latch_next;
    logic [19:0] pgain_reg, pgain_next;
    logic [19:0] igain_reg, igain_next;

    // per-update working registers
    logic [16:0] dt_reg, dt_next;
    logic [16:0] thr_reg, thr_next;
    logic [16:0] tgt_reg, tgt_next;
    logic ign_reg, ign_next;
    logic signed [43:0] prod_reg;
    logic [32:0] acc_reg, acc_next;
    logic signed [27:0] p_reg, p_next;
    logic signed [20:0] raw_reg, raw_next;
    logic signed [24:0] curved_reg, curved_next;
    logic [16:0] load_reg, load_next;
    logic [17:0] aim_reg, aim_next;
    logic [16:0] up_reg, up_next;
    logic [12:0] exh_reg, exh_next;
    logic [18:0] q_reg, q_next;
    logic [17:0] pres_reg, pres_next;

    // result register
    logic [16:0] o_speed_reg, o_load_reg;
    logic [12:0] o_exh_reg;
    logic [17:0] o_pres_reg;
    logic o_start_reg;

    logic signed [21:0] mul_a, mul_b;
    logic [43:0] pu;
    logic [43:0] pu_half;
    logic [16:0] rnd16;
    logic signed [17:0] err;
    logic signed [17:0] dspd;
    logic [16:0] sel;
    logic [33:0] ssum;
    logic [17:0] rnew;
    logic signed [43:0] tz4, tz12, tz24;
    logic signed [31:0] isum;
    logic signed [28:0] rsum;
    logic [15:0] mr;
    logic signed [25:0] d, lim;
    logic [16:0] a_ctl;
    logic [17:0] c_up, c_lo, c_new;
    logic [16:0] dec;

    assign err  = $signed({1'b0, tgt_reg}) - $signed({1'b0, cur_reg});
    assign dspd = $signed({1'b0, cur_reg}) - $signed({1'b0, prev_spd_reg});

    always_comb
    begin
        if (thr_reg < 17'd6554)
            sel = 17'd58982;
        else if (thr_reg < 17'd19661)
            sel = 17'd52429;
        else
            sel = 17'd45875;
    end

    // shared multiplier operands
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.step)
            S_OFF_MUL, S_AM_M2:
            begin
                mul_a = $signed({5'b0, dt_reg});
                mul_b = 22'sd8000;
            end
            S_SM_M1:
            begin
                mul_a = $signed({5'b0, ratio_reg});
                mul_b = 22'sd62259;
            end
            S_SM_M2:
            begin
                mul_a = $signed({5'b0, sel});
                mul_b = 22'sd3277;
            end
            S_SM_M3:
            begin
                mul_a = $signed({5'b0, thr_reg});
                mul_b = $signed({5'b0, ratio_reg});
            end
            S_SM_M4:
            begin
                mul_a = $signed({5'b0, st_reg});
                mul_b = $signed({5'b0, 17'(ONE_V - ratio_reg)});
            end
            S_CT_M1:
            begin
                mul_a = {{4{err[17]}}, err};
                mul_b = $signed({2'b0, pgain_reg});
            end
            S_CT_M2:
            begin
                mul_a = {{4{dspd[17]}}, dspd};
                mul_b = 22'sd1678;
            end
            S_CT_M3:
            begin
                mul_a = {{4{err[17]}}, err};
                mul_b = $signed({5'b0, dt_reg});
            end
            S_CT_M5:
            begin
                mul_a = {{4{integ_reg[17]}}, integ_reg};
                mul_b = $signed({2'b0, igain_reg});
            end
            S_CT_M7:
            begin
                mul_a = {raw_reg[20], raw_reg};
                mul_b = {raw_reg[20], raw_reg};
            end
            S_AM_M1:
            begin
                mul_a = $signed({5'b0, load_reg});
                mul_b = 22'sd83200;
            end
            S_AM_M3:
            begin
                mul_a = $signed({5'b0, dt_reg});
                mul_b = 22'sd80000;
            end
            S_AM_M4:
            begin
                mul_a = $signed({5'b0, dt_reg});
                mul_b = 22'sd24000;
            end
            S_OU_M1:
            begin
                mul_a = $signed({4'b0, 18'({1'b0, load_reg} + 18'd5)});
                mul_b = 22'sd104858;
            end
            S_OU_M2:
            begin
                mul_a = $signed({5'b0, load_reg});
                mul_b = 22'sd303975;
            end
            S_OU_M4:
            begin
                mul_a = $signed({3'b0, q_reg});
                mul_b = 22'sd838861;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign pu      = prod_reg;
    assign pu_half = pu + 44'd32768;
    assign rnd16   = pu_half[32:16];
    assign tz4     = shr_tz(prod_reg, 5'd4);
    assign tz12    = shr_tz(prod_reg, 5'd12);
    assign tz24    = shr_tz(prod_reg, 5'd24);

    always_comb
    begin
        cur_next      = cur_reg;
        ratio_next    = ratio_reg;
        st_next       = st_reg;
        integ_next    = integ_reg;
        prev_spd_next = prev_spd_reg;
        prev_drv_next = prev_drv_reg;
        latch_next    = latch_reg;
        pgain_next    = pgain_reg;
        igain_next    = igain_reg;
        dt_next       = dt_reg;
        thr_next      = thr_reg;
        tgt_next      = tgt_reg;
        ign_next      = ign_reg;
        acc_next      = acc_reg;
        p_next        = p_reg;
        raw_next      = raw_reg;
        curved_next   = curved_reg;
        load_next     = load_reg;
        aim_next      = aim_reg;
        up_next       = up_reg;
        exh_next      = exh_reg;
        q_next        = q_reg;
        pres_next     = pres_reg;

        ssum  = {1'b0, acc_reg} + {1'b0, pu[32:0]} + 34'd32768;
        rnew  = ssum[33:16];
        isum  = 32'(integ_reg) + tz4[31:0];
        rsum  = 29'(p_reg) + 29'($signed(tz24[11:0]));
        mr    = dt_reg[16:1];
        d     = 26'(curved_reg) - 26'(prev_drv_reg);
        lim   = 26'(curved_reg);
        a_ctl = '0;
        dec   = rnd16;
        c_up  = {1'b0, cur_reg} + {1'b0, up_reg};
        c_lo  = (cur_reg > rnd16) ? {1'b0, 17'(cur_reg - rnd16)} : 18'd0;
        c_new = {1'b0, cur_reg};

        if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_PROP_GAIN:  pgain_next = cfg_data;
                CFG_INTEG_GAIN: igain_next = cfg_data;
                default:        pgain_next = pgain_reg;
            endcase
        end

        if (cmd.load)
        begin
            dt_next  = (step_time > ONE_V) ? ONE_V : step_time;
            thr_next = (throttle_cmd > ONE_V) ? ONE_V : throttle_cmd;
            tgt_next = speed_target;
            ign_next = ignition_on;
            if (starter_press)
                latch_next = 1'b1;
        end

        case (cmd.step)
            S_OFF_UPD:
            begin
                cur_next  = (cur_reg > dec) ? 17'(cur_reg - dec) : 17'd0;
                load_next = '0;
            end
            S_SM_M2, S_SM_M4:
                acc_next = pu[32:0];
            S_SM_R:
                ratio_next = (rnew > 18'(ONE_V)) ? ONE_V : rnew[16:0];
            S_SM_ST:
            begin
                st_next   = rnew[16:0];
                load_next = rnew[16:0];
            end
            S_CT_LOW:
                if (load_reg < 17'd6554)
                    load_next = 17'd6554;
            S_CT_M2:
                p_next = tz12[27:0];
            S_CT_M3:
                if (cur_reg < 17'd32000)
                    p_next = p_reg - tz12[27:0];
            S_CT_M4:
            begin
                if (isum < -32'sd32768)
                    integ_next = -18'sd32768;
                else if (isum > 32'sd32768)
                    integ_next = 18'sd32768;
                else
                    integ_next = isum[17:0];
            end
            S_CT_M6:
            begin
                if (rsum < -29'sd524288)
                    raw_next = -21'sd524288;
                else if (rsum > 29'sd524288)
                    raw_next = 21'sd524288;
                else
                    raw_next = rsum[20:0];
            end
            S_CT_M8:
            begin
                if (raw_reg < 21'sd32768)
                    curved_next = $signed({1'b0, pu[38:15]});
                else
                    curved_next = 25'(raw_reg);
            end
            S_CT_M9:
            begin
                if (d > $signed({10'b0, mr}))
                    lim = 26'(prev_drv_reg) + $signed({10'b0, mr});
                else if (d < -$signed({10'b0, mr}))
                    lim = 26'(prev_drv_reg) - $signed({10'b0, mr});
                else
                    lim = 26'(curved_reg);
                prev_spd_next = cur_reg;
                if (lim < -26'sd262144)
                    prev_drv_next = -19'sd262144;
                else if (lim > 26'sd262143)
                    prev_drv_next = 19'sd262143;
                else
                    prev_drv_next = lim[18:0];
                if (lim < 26'sd0)
                    a_ctl = '0;
                else if (lim > 26'sd65536)
                    a_ctl = ONE_V;
                else
                    a_ctl = lim[16:0];
                if (a_ctl > load_reg)
                    load_next = a_ctl;
            end
            S_AM_M2:
                aim_next = 18'd12800 + {1'b0, rnd16};
            S_AM_M3:
                if (latch_reg && cur_reg < 17'd9600)
                    aim_next = ((aim_reg > 18'd16000) ? 18'd16000 : aim_reg)
                               + {1'b0, rnd16};
            S_AM_M4:
                up_next = rnd16;
            S_AM_M5:
            begin
                if (aim_reg > {1'b0, cur_reg})
                    c_new = (aim_reg < c_up) ? aim_reg : c_up;
                else
                    c_new = (aim_reg > c_lo) ? aim_reg : c_lo;
                if (c_new > 18'd131071)
                    c_new = 18'd131071;
                cur_next = c_new[16:0];
                if (latch_reg && c_new > 18'd8800)
                    latch_next = 1'b0;
            end
            S_OU_M2:
                exh_next = pu[32:20];
            S_OU_M3:
                q_next = 19'((pu + 44'd327680) >> 16);
            S_OU_M5:
                pres_next = 18'd101325 + {3'b0, pu[37:23]};
            default:
                acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg      <= '0;
            ratio_reg    <= 17'd52429;
            st_reg       <= '0;
            integ_reg    <= '0;
            prev_spd_reg <= '0;
            prev_drv_reg <= '0;
            latch_reg    <= 1'b0;
            pgain_reg    <= 20'd33554;
            igain_reg    <= 20'd1678;
        end
        else
        begin
            cur_reg      <= cur_next;
            ratio_reg    <= ratio_next;
            st_reg       <= st_next;
            integ_reg    <= integ_next;
            prev_spd_reg <= prev_spd_next;
            prev_drv_reg <= prev_drv_next;
            latch_reg    <= latch_next;
            pgain_reg    <= pgain_next;
            igain_reg    <= igain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dt_reg     <= dt_next;
        thr_reg    <= thr_next;
        tgt_reg    <= tgt_next;
        ign_reg    <= ign_next;
        prod_reg   <= mul_a * mul_b;
        acc_reg    <= acc_next;
        p_reg      <= p_next;
        raw_reg    <= raw_next;
        curved_reg <= curved_next;
        load_reg   <= load_next;
        aim_reg    <= aim_next;
        up_reg     <= up_next;
        exh_reg    <= exh_next;
        q_reg      <= q_next;
        pres_reg   <= pres_next;
        if (cmd.publish)
        begin
            o_speed_reg <= cur_reg;
            o_load_reg  <= load_reg;
            o_exh_reg   <= exh_reg;
            o_pres_reg  <= pres_reg;
            o_start_reg <= latch_reg;
        end
    end

    assign stat.ign     = ign_reg;
    assign stat.tgt_nz  = (tgt_reg != '0);
    assign stat.cur_low = (cur_reg < 17'd1600);

    assign engine_speed      = o_speed_reg;
    assign engine_load       = o_load_reg;
    assign exhaust_flow      = o_exh_reg;
    assign manifold_pressure = o_pres_reg;
    assign starter_active    = o_start_reg;

endmodule

`default_nettype wire

// ===== design/engine_speed_throttle_step.sv =====
// Engine speed and throttle update. One beat in gives one beat out. An update
// runs through a sequencer that feeds a single shared 22x22 multiplier, one
// product per cycle. The sequence is longest with ignition on and the speed
// controller running, shorter with ignition on and the speed below the
// low-speed limit, shorter again with ignition on and no speed target, and
// shortest with ignition off. The finished result sits in an output register,
// so the next beat is taken while it waits; a new result is held back only if
// the previous one has still not been taken by then.
// top level; depends on est_pkg, est_ctrl and est_dp
`default_nettype none

module engine_speed_throttle_step
    import est_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [55:0] s_tdata,  // step_time, throttle_cmd, speed_target
    input  wire logic [1:0]  s_tuser,  // ignition_on, starter_press
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // engine_speed, engine_load, exhaust_flow, manifold_pressure
    output logic [71:0]      m_tdata,
    output logic [0:0]       m_tuser,  // starter_active
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [19:0] cfg_data
);

    cmd_t        cmd;
    status_t     stat;
    logic [16:0] engine_speed;
    logic [16:0] engine_load;
    logic [12:0] exhaust_flow;
    logic [17:0] manifold_pressure;
    logic        starter_active;

    est_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    est_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .stat              (stat),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .step_time         (s_tdata[16:0]),
        .throttle_cmd      (s_tdata[33:17]),
        .speed_target      (s_tdata[50:34]),
        .ignition_on       (s_tuser[0]),
        .starter_press     (s_tuser[1]),
        .engine_speed      (engine_speed),
        .engine_load       (engine_load),
        .exhaust_flow      (exhaust_flow),
        .manifold_pressure (manifold_pressure),
        .starter_active    (starter_active)
    );

    assign m_tdata = {7'b0, manifold_pressure, exhaust_flow, engine_load, engine_speed};
    assign m_tuser = starter_active;

endmodule

`default_nettype wire
